/* hdl/lidar_packet_deframer_crc8_core_assert.svh */
// assertion macros used by the checker file
`ifndef LIDAR_PACKET_DEFRAMER_CRC8_CORE_ASSERT_SVH
`define LIDAR_PACKET_DEFRAMER_CRC8_CORE_ASSERT_SVH

// clocked assertion, quiet while reset is asserted
`define LPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked assertion that also holds during reset
`define LPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

/* hdl/lpd_pkg.sv */
// shared types, constants and crc function of the lidar packet deframer
package lpd_pkg;

	localparam logic [7:0] HDR0     = 8'h54;
	localparam logic [7:0] HDR1     = 8'h2C;
	localparam logic [7:0] CRC_POLY = 8'h4D;
	localparam int         PTS_BASE = 6;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_HDR1,
		ST_BODY,
		ST_READ,
		ST_SHOW
	} state_t;

	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_SEED,
		CRC_FEED
	} crc_op_t;

	typedef enum logic [3:0] {
		CAP_NONE,
		CAP_LOW,
		CAP_SPEED,
		CAP_START,
		CAP_END,
		CAP_TS,
		CAP_DIST,
		CAP_CONF,
		CAP_CRC
	} cap_t;

	typedef struct packed {
		crc_op_t crc_op;
		cap_t    cap;
		logic    rd_en;
	} cmd_t;

	typedef struct packed {
		logic is_hdr0;
		logic is_hdr1;
	} status_t;

	// msb-first crc-8, one byte
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hdl/lpd_ctrl.sv */
// controller: header hunt, byte position tracking and result sequencing
module lpd_ctrl #(
	parameter int POINTS_PER_FRAME = 12,
	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lpd_pkg::status_t     status,
	output lpd_pkg::cmd_t        cmd,
	output logic [IW-1:0]        wr_addr,
	output logic [IW-1:0]        rd_addr,
	output logic [3:0]           point_index,
	output logic                 last_point
);

	localparam int PTS_END = lpd_pkg::PTS_BASE + 3 * POINTS_PER_FRAME;
	localparam int EA_POS  = PTS_END;
	localparam int TS_POS  = PTS_END + 2;
	localparam int CRC_POS = PTS_END + 4;
	localparam int PW      = $clog2(CRC_POS + 1);

	lpd_pkg::state_t state_q, state_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [IW-1:0]   pt_idx_q, pt_idx_d;
	logic [1:0]      pt_k_q, pt_k_d;
	logic [IW-1:0]   emit_q, emit_d;
	logic            in_points;
	logic            is_last;

	assign in_points = (pos_q >= PW'(lpd_pkg::PTS_BASE)) && (pos_q < PW'(PTS_END));
	assign is_last   = (emit_q == IW'(POINTS_PER_FRAME - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lpd_pkg::ST_HUNT;
			pos_q    <= '0;
			pt_idx_q <= '0;
			pt_k_q   <= '0;
			emit_q   <= '0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			pt_idx_q <= pt_idx_d;
			pt_k_q   <= pt_k_d;
			emit_q   <= emit_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		pt_idx_d   = pt_idx_q;
		pt_k_d     = pt_k_q;
		emit_d     = emit_q;
		cmd.crc_op = lpd_pkg::CRC_HOLD;
		cmd.cap    = lpd_pkg::CAP_NONE;
		cmd.rd_en  = 1'b0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			lpd_pkg::ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid && status.is_hdr0) begin
					cmd.crc_op = lpd_pkg::CRC_SEED;
					state_d    = lpd_pkg::ST_HDR1;
				end
			end
			lpd_pkg::ST_HDR1: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (status.is_hdr1) begin
						cmd.crc_op = lpd_pkg::CRC_FEED;
						state_d    = lpd_pkg::ST_BODY;
						pos_d      = PW'(2);
						pt_idx_d   = '0;
						pt_k_d     = '0;
					end else if (status.is_hdr0) begin
						// repeated first header byte restarts the crc
						cmd.crc_op = lpd_pkg::CRC_SEED;
					end else begin
						state_d = lpd_pkg::ST_HUNT;
					end
				end
			end
			lpd_pkg::ST_BODY: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (pos_q == PW'(CRC_POS)) begin
						cmd.cap = lpd_pkg::CAP_CRC;
						emit_d  = '0;
						state_d = lpd_pkg::ST_READ;
					end else begin
						cmd.crc_op = lpd_pkg::CRC_FEED;
						pos_d      = pos_q + PW'(1);
						if (pos_q == PW'(2) || pos_q == PW'(4) ||
						    pos_q == PW'(EA_POS) || pos_q == PW'(TS_POS)) begin
							cmd.cap = lpd_pkg::CAP_LOW;
						end else if (pos_q == PW'(3)) begin
							cmd.cap = lpd_pkg::CAP_SPEED;
						end else if (pos_q == PW'(5)) begin
							cmd.cap = lpd_pkg::CAP_START;
						end else if (pos_q == PW'(EA_POS + 1)) begin
							cmd.cap = lpd_pkg::CAP_END;
						end else if (pos_q == PW'(TS_POS + 1)) begin
							cmd.cap = lpd_pkg::CAP_TS;
						end else if (in_points) begin
							case (pt_k_q)
								2'd0: begin
									cmd.cap = lpd_pkg::CAP_LOW;
									pt_k_d  = 2'd1;
								end
								2'd1: begin
									cmd.cap = lpd_pkg::CAP_DIST;
									pt_k_d  = 2'd2;
								end
								default: begin
									cmd.cap  = lpd_pkg::CAP_CONF;
									pt_k_d   = 2'd0;
									pt_idx_d = pt_idx_q + IW'(1);
								end
							endcase
						end
					end
				end
			end
			lpd_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = lpd_pkg::ST_SHOW;
			end
			lpd_pkg::ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (is_last) begin
						state_d = lpd_pkg::ST_HUNT;
					end else begin
						emit_d  = emit_q + IW'(1);
						state_d = lpd_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = lpd_pkg::ST_HUNT;
			end
		endcase
	end

	assign wr_addr     = pt_idx_q;
	assign rd_addr     = emit_q;
	assign point_index = 4'(emit_q);
	assign last_point  = is_last;

endmodule

/* hdl/lpd_datapath.sv */
// datapath: crc register, field holds and point memory
module lpd_datapath #(
	parameter int POINTS_PER_FRAME = 12,
	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1
) (
	input  logic              clk,
	input  logic [7:0]        rx_byte,
	input  lpd_pkg::cmd_t     cmd,
	input  logic [IW-1:0]     wr_addr,
	input  logic [IW-1:0]     rd_addr,
	output lpd_pkg::status_t  status,
	output logic [15:0]       distance_mm,
	output logic [7:0]        confidence,
	output logic [15:0]       motor_speed,
	output logic [15:0]       start_angle,
	output logic [15:0]       end_angle,
	output logic [15:0]       frame_timestamp,
	output logic [7:0]        crc_received,
	output logic [7:0]        crc_computed,
	output logic              crc_ok
);

	logic [7:0]  crc_q;
	logic [7:0]  low_q;
	logic [15:0] speed_q;
	logic [15:0] start_q;
	logic [15:0] end_q;
	logic [15:0] ts_q;
	logic [15:0] dist_q;
	logic [7:0]  rx_crc_q;
	logic        ok_q;
	logic [23:0] rd_q;
	logic [23:0] mem_q [POINTS_PER_FRAME];
	logic [15:0] word;

	assign word           = {rx_byte, low_q};
	assign status.is_hdr0 = (rx_byte == lpd_pkg::HDR0);
	assign status.is_hdr1 = (rx_byte == lpd_pkg::HDR1);

	always_ff @(posedge clk) begin
		case (cmd.crc_op)
			lpd_pkg::CRC_SEED: crc_q <= lpd_pkg::crc_feed(8'h00, rx_byte);
			lpd_pkg::CRC_FEED: crc_q <= lpd_pkg::crc_feed(crc_q, rx_byte);
			default:           crc_q <= crc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.cap)
			lpd_pkg::CAP_LOW:   low_q   <= rx_byte;
			lpd_pkg::CAP_SPEED: speed_q <= word;
			lpd_pkg::CAP_START: start_q <= word;
			lpd_pkg::CAP_END:   end_q   <= word;
			lpd_pkg::CAP_TS:    ts_q    <= word;
			lpd_pkg::CAP_DIST:  dist_q  <= word;
			lpd_pkg::CAP_CONF:  mem_q[wr_addr] <= {rx_byte, dist_q};
			lpd_pkg::CAP_CRC: begin
				rx_crc_q <= rx_byte;
				ok_q     <= (crc_q == rx_byte);
			end
			default: begin
			end
		endcase
	end

	// single registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign distance_mm     = rd_q[15:0];
	assign confidence      = rd_q[23:16];
	assign motor_speed     = speed_q;
	assign start_angle     = start_q;
	assign end_angle       = end_q;
	assign frame_timestamp = ts_q;
	assign crc_received    = rx_crc_q;
	assign crc_computed    = crc_q;
	assign crc_ok          = ok_q;

endmodule

/* hdl/lidar_packet_deframer_crc8_core.sv */
// top level of the lidar packet deframer with crc-8 check
//
//  channel   handshake              payload
//  in        in_valid / in_ready    rx_byte, one serial byte per word
//  out       out_valid / out_ready  one point result per word, frame fields alongside
//
// header and body bytes are taken one word per cycle; in_ready stays high while
// hunting or collecting a frame.
// the crc byte starts a burst of POINTS_PER_FRAME results; each is read from the point
// memory through its single registered port and then shown, and no input word is
// taken during the burst.
// out_ready low holds the current result and stalls the burst; nothing is lost.
// arst_n clears the controller to the header hunt; payload registers are not reset.
module lidar_packet_deframer_crc8_core #(
	parameter int POINTS_PER_FRAME = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] distance_mm,
	output logic [7:0]  confidence,
	output logic [3:0]  point_index,
	output logic [15:0] motor_speed,
	output logic [15:0] start_angle,
	output logic [15:0] end_angle,
	output logic [15:0] frame_timestamp,
	output logic [7:0]  crc_received,
	output logic [7:0]  crc_computed,
	output logic        crc_ok,
	output logic        last_point
);

	// point memory address width
	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

	lpd_pkg::cmd_t    cmd;
	lpd_pkg::status_t status;
	logic [IW-1:0]    wr_addr;
	logic [IW-1:0]    rd_addr;

	// controller: sync phase, byte position, point counters, result sequence
	lpd_ctrl #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.point_index(point_index),
		.last_point (last_point)
	);

	// datapath: running crc, little-endian field assembly, point memory
	lpd_datapath #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_dp (
		.clk            (clk),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr),
		.status         (status),
		.distance_mm    (distance_mm),
		.confidence     (confidence),
		.motor_speed    (motor_speed),
		.start_angle    (start_angle),
		.end_angle      (end_angle),
		.frame_timestamp(frame_timestamp),
		.crc_received   (crc_received),
		.crc_computed   (crc_computed),
		.crc_ok         (crc_ok)
	);

endmodule

/* hdl/lpd_checker.sv */
// port-level checks for the lidar packet deframer, bound to the top level
`include "lidar_packet_deframer_crc8_core_assert.svh"

module lpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] distance_mm,
	input logic [3:0]  point_index,
	input logic [7:0]  crc_received,
	input logic [7:0]  crc_computed,
	input logic        crc_ok,
	input logic        last_point
);

	// a stalled result keeps its payload
	`LPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(distance_mm) && $stable(point_index), "result changed while stalled")

	// no byte is taken while a burst is being delivered
	`LPD_ASSERT(a_no_in_during_burst, out_valid |-> !in_ready, "input taken during result burst")

	// the final result hands back to the header hunt
	`LPD_ASSERT(a_last_resumes, out_valid && out_ready && last_point |=> in_ready && !out_valid, "no return to hunt after last point")

	// match flag agrees with the two crc values
	`LPD_ASSERT(a_crc_flag, out_valid |-> (crc_ok == (crc_received == crc_computed)), "crc flag inconsistent")

	// reset empties the output side
	`LPD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result shown during reset")

endmodule

bind lidar_packet_deframer_crc8_core lpd_checker u_lpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.distance_mm (distance_mm),
	.point_index (point_index),
	.crc_received(crc_received),
	.crc_computed(crc_computed),
	.crc_ok      (crc_ok),
	.last_point  (last_point)
);
